// ----- rtl/bbmf_pkg.sv -----
// Package for the byte-budget message FIFO: item types, codes and fixed widths.
// Used by every module of the block but bbmf_ram; depends on nothing.
package bbmf_pkg;

    // Fixed field widths of the item and of the configuration registers.
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int LIMIT_W = 5;
    localparam int BYTES_W = 20;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 1;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_FORCE = 2'd1,
        MODE_DEQ   = 2'd2,
        MODE_PEEK  = 2'd3
    } mode_t;

    // Status codes of a result item.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_LIMIT = 1'd0,
        CFG_BYTE_BUDGET = 1'd1
    } cfg_idx_t;

    // Input item.
    typedef struct packed {
        mode_t              mode;
        logic [DATA_W-1:0]  payload;
        logic [SIZE_W-1:0]  msg_bytes;
    } in_item_t;

    // Result item.
    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data_out;
        logic [SIZE_W-1:0]   data_bytes;
        logic [LIMIT_W-1:0]  entries_held;
        logic [BYTES_W-1:0]  bytes_held;
        logic [LIMIT_W-1:0]  dropped_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    pop;
        logic    push;
        logic    finish;
        status_t status;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  too_large;
        logic  need_room;
        logic  empty;
    } dp_stat_t;

endpackage

// ----- rtl/bbmf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module bbmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bbmf_ctrl.sv -----
// Controller state machine of the byte-budget message FIFO.
// Depends on bbmf_pkg; drives the datapath through ctrl_cmd_t.
module bbmf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bbmf_pkg::dp_stat_t stat,
    output bbmf_pkg::ctrl_cmd_t cmd
);

    import bbmf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide the operation. A forced enqueue stays in evaluation, dropping one
    // message per cycle, until the new message fits or the queue is empty.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                cmd.finish = 1'b1;
                case (stat.mode) inside
                    MODE_ENQ, MODE_FORCE:
                    begin
                        if (stat.too_large)
                        begin
                            cmd.status = ST_TOO_LARGE;
                        end
                        else if (stat.mode == MODE_ENQ && stat.need_room)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else if (stat.mode == MODE_FORCE && stat.need_room && !stat.empty)
                        begin
                            cmd.pop    = 1'b1;
                            cmd.finish = 1'b0;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else if (stat.mode == MODE_DEQ)
                        begin
                            cmd.pop = 1'b1;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/bbmf_dpath.sv -----
// Datapath of the byte-budget message FIFO: configuration, slots, counters,
// message RAM and result register. Depends on bbmf_pkg and bbmf_ram.
module bbmf_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbmf_pkg::in_item_t            in_item,
    input  logic                          cfg_we,
    input  logic [bbmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbmf_pkg::CFG_W-1:0]    cfg_data,
    input  bbmf_pkg::ctrl_cmd_t           cmd,
    output bbmf_pkg::dp_stat_t            stat,
    output logic                          done,
    output bbmf_pkg::out_item_t           result
);

    import bbmf_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CMP_W  = (SLOT_W + 1 > LIMIT_W) ? SLOT_W + 1 : LIMIT_W;
    localparam int WORD_W = DATA_W + SIZE_W;

    logic [LIMIT_W-1:0] entry_limit_reg;
    logic [BYTES_W-1:0] byte_budget_reg;
    in_item_t           item_reg;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic [BYTES_W-1:0] total_reg, total_next;
    logic [LIMIT_W-1:0] dropped_reg, dropped_next;
    logic               done_reg;
    out_item_t          result_reg;

    logic [LIMIT_W-1:0] eff_limit;
    logic [WORD_W-1:0]  rd_word;
    logic [DATA_W-1:0]  front_data;
    logic [SIZE_W-1:0]  front_size;
    logic [BYTES_W:0]   sum_after;
    logic               full;
    logic               is_read_mode;

    // Advance a slot, wrapping to zero at the effective entry limit.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [LIMIT_W-1:0] lim);
        logic [CMP_W-1:0] n;
        n = CMP_W'(s) + CMP_W'(1);
        next_slot = (n >= CMP_W'(lim)) ? '0 : n[SLOT_W-1:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_limit_reg <= LIMIT_W'(16);
            byte_budget_reg <= {BYTES_W{1'b1}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENTRY_LIMIT: entry_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_BYTE_BUDGET: byte_budget_reg <= cfg_data[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective entry limit: zero acts as one, values above DEPTH act as DEPTH.
    always_comb
    begin
        if (entry_limit_reg == '0)
        begin
            eff_limit = LIMIT_W'(1);
        end
        else if (int'(entry_limit_reg) > DEPTH)
        begin
            eff_limit = LIMIT_W'(DEPTH);
        end
        else
        begin
            eff_limit = entry_limit_reg;
        end
    end

    assign front_data = rd_word[WORD_W-1:SIZE_W];
    assign front_size = rd_word[SIZE_W-1:0];

    // Room checks on the current counters.
    assign full      = (count_reg >= eff_limit) || (total_reg >= byte_budget_reg);
    assign sum_after = {1'b0, total_reg} + (BYTES_W + 1)'(item_reg.msg_bytes);

    assign stat.mode      = item_reg.mode;
    assign stat.too_large = BYTES_W'(item_reg.msg_bytes) > byte_budget_reg;
    assign stat.need_room = full || (sum_after > {1'b0, byte_budget_reg});
    assign stat.empty     = (count_reg == '0);

    // Next values of slots and counters for a pop or a push; a load clears the drop count.
    always_comb
    begin
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        dropped_next    = dropped_reg;
        if (cmd.load)
        begin
            dropped_next = '0;
        end
        if (cmd.pop)
        begin
            read_slot_next = next_slot(read_slot_reg, eff_limit);
            count_next     = count_reg - LIMIT_W'(1);
            total_next     = (BYTES_W'(front_size) > total_reg) ? '0
                             : total_reg - BYTES_W'(front_size);
            if (item_reg.mode == MODE_FORCE)
            begin
                dropped_next = dropped_reg + LIMIT_W'(1);
            end
        end
        if (cmd.push)
        begin
            write_slot_next = next_slot(write_slot_reg, eff_limit);
            count_next      = count_reg + LIMIT_W'(1);
            total_next      = sum_after[BYTES_W-1:0];
        end
    end

    // Queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_slot_reg  <= '0;
            write_slot_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            dropped_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            dropped_reg    <= dropped_next;
            done_reg       <= cmd.finish;
        end
    end

    // Item and result payload registers.
    assign is_read_mode = (item_reg.mode == MODE_DEQ) || (item_reg.mode == MODE_PEEK);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.finish)
        begin
            result_reg.status        <= cmd.status;
            result_reg.data_out      <= (is_read_mode && cmd.status == ST_OK) ? front_data : '0;
            result_reg.data_bytes    <= (is_read_mode && cmd.status == ST_OK) ? front_size : '0;
            result_reg.entries_held  <= count_next;
            result_reg.bytes_held    <= total_next;
            result_reg.dropped_count <= dropped_reg;
        end
    end

    // Message memory; the read port follows the front slot every cycle.
    bbmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (write_slot_reg),
        .wdata ({item_reg.payload, item_reg.msg_bytes}),
        .raddr (read_slot_next),
        .rdata (rd_word)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/byte_budget_message_fifo.sv -----
// Top level of the byte-budget message FIFO: controller plus datapath.
// Depends on bbmf_pkg, bbmf_ctrl, bbmf_dpath and bbmf_ram.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+----------------------
//   command  | start / busy        | cmd (in_item_t)
//   result   | done (one cycle)    | result (out_item_t)
//   config   | cfg_we              | cfg_index, cfg_data
//
// An item is taken when start is high and busy is low. It is registered as
// the controller enters evaluation, and done rises together with the registered
// result; a forced enqueue stays in evaluation while it drops messages, the
// evaluation loop reading one front entry per cycle from the message RAM. One
// item is worked on at a time. done is high for a single cycle and the receiver
// cannot stall it; result holds until the next item finishes. Reset clears
// the queue and restores the configuration defaults; the message RAM is not cleared.
module byte_budget_message_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bbmf_pkg::in_item_t             cmd,
    output logic                           done,
    output bbmf_pkg::out_item_t            result,
    input  logic                           cfg_we,
    input  logic [bbmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbmf_pkg::CFG_W-1:0]     cfg_data
);

    import bbmf_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    bbmf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (dp_stat),
        .cmd   (ctrl_cmd)
    );

    bbmf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat),
        .done      (done),
        .result    (result)
    );

endmodule
